// ----- rtl/sorg_pkg.sv -----
// ----------------------------------------------------------------------------
// sorg_pkg
// Shared sizes and types for the span ownership registry.
// ----------------------------------------------------------------------------
package sorg_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_BITS   = 48;
    localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // start of the range and its length modulo 2^ADDR_BITS (end - start)
    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] span;
    } entry_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] idx;
        entry_t              entry;
    } table_wr_t;

endpackage

// ----- rtl/span_ownership_registry_top.sv -----
// ----------------------------------------------------------------------------
// span_ownership_registry_top
// Append-only table of up to TABLE_DEPTH address ranges with an ownership
// query. An accepted add is recorded, or dropped when the table is full, and
// its result is loaded into the output register from ST_DONE. A query scans
// the recorded entries through the one read port of the table, one entry per
// cycle, then drains the read and compare registers through ST_WAIT1 and
// ST_WAIT2 before ST_DONE loads its result; an empty-table query goes straight
// to ST_DONE. The block takes one item at a time and is ready again the cycle
// after a result is loaded. A finished result waits in the output register
// while the next item is accepted; a result not yet taken holds the next one
// back. Table contents need no clearing after reset.
// ----------------------------------------------------------------------------
module span_ownership_registry_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // address [47:0], span_length [95:48]
    input  logic [2*sorg_pkg::ADDR_BITS-1:0]     s_tdata,
    // req_type [0]
    input  logic [0:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // found [0], dropped [1], entries_used [14:2], zero [15]
    output logic [15:0]                          m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT1,
        ST_WAIT2,
        ST_DONE
    } state_t;

    state_t                           state_reg;
    logic [sorg_pkg::COUNT_BITS-1:0]  count_reg;
    logic [sorg_pkg::IDX_BITS-1:0]    idx_reg;
    logic [sorg_pkg::ADDR_BITS-1:0]   probe_reg;
    logic                             rvalid_reg;
    logic                             found_reg;
    logic                             dropped_reg;
    logic                             m_tvalid_reg;
    logic [15:0]                      m_tdata_reg;

    logic                             s_accept;
    logic                             full;
    logic [sorg_pkg::ADDR_BITS-1:0]   in_addr;
    logic [sorg_pkg::ADDR_BITS-1:0]   in_len;
    logic [sorg_pkg::IDX_BITS-1:0]    last_idx;
    logic [sorg_pkg::COUNT_BITS-1:0]  count_dec;
    logic                             rd_en;
    logic                             hit;
    sorg_pkg::table_wr_t              wr;
    sorg_pkg::entry_t                 rd_entry;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_addr  = s_tdata[sorg_pkg::ADDR_BITS-1:0];
    assign in_len   = s_tdata[2*sorg_pkg::ADDR_BITS-1:sorg_pkg::ADDR_BITS];
    assign full     = (count_reg == sorg_pkg::COUNT_BITS'(sorg_pkg::TABLE_DEPTH));
    assign count_dec = count_reg - sorg_pkg::COUNT_BITS'(1);
    assign last_idx  = count_dec[sorg_pkg::IDX_BITS-1:0];
    assign rd_en     = (state_reg == ST_SCAN);

    always_comb begin
        wr.en          = s_accept && (s_tuser[0] == sorg_pkg::REQ_ADD) && !full;
        wr.idx         = count_reg[sorg_pkg::IDX_BITS-1:0];
        wr.entry.start = in_addr;
        wr.entry.span  = in_len;
    end

    sorg_table u_table (
        .aclk     (aclk),
        .wr       (wr),
        .rd_en    (rd_en),
        .rd_idx   (idx_reg),
        .rd_entry (rd_entry)
    );

    sorg_match u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid   (rvalid_reg),
        .probe   (probe_reg),
        .entry   (rd_entry),
        .hit     (hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            rvalid_reg   <= 1'b0;
            found_reg    <= 1'b0;
            dropped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rvalid_reg <= rd_en;
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        found_reg   <= 1'b0;
                        dropped_reg <= (s_tuser[0] == sorg_pkg::REQ_ADD) && full;
                        probe_reg   <= in_addr;
                        idx_reg     <= '0;
                        if (s_tuser[0] == sorg_pkg::REQ_ADD) begin
                            if (!full) begin
                                count_reg <= count_reg + sorg_pkg::COUNT_BITS'(1);
                            end
                            state_reg <= ST_DONE;
                        end else if (count_reg == '0) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    found_reg <= found_reg | hit;
                    idx_reg   <= idx_reg + sorg_pkg::IDX_BITS'(1);
                    if (idx_reg == last_idx) begin
                        state_reg <= ST_WAIT1;
                    end
                end
                ST_WAIT1: begin
                    found_reg <= found_reg | hit;
                    state_reg <= ST_WAIT2;
                end
                ST_WAIT2: begin
                    found_reg <= found_reg | hit;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, count_reg, dropped_reg, found_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sorg_pkg::COUNT_BITS'(sorg_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser[0] == sorg_pkg::REQ_ADD) && !full)
        |=> (count_reg == $past(count_reg) + sorg_pkg::COUNT_BITS'(1)))
        else $error("add did not record a range");

    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rvalid_reg |-> (state_reg == ST_SCAN || state_reg == ST_WAIT1))
        else $error("table read outside a scan");

    a_query_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> $stable(count_reg))
        else $error("entry count changed during a scan");
`endif

endmodule

// ----- rtl/sorg_table.sv -----
// ----------------------------------------------------------------------------
// sorg_table
// Range table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sorg_table (
    input  logic                          aclk,
    input  sorg_pkg::table_wr_t           wr,
    input  logic                          rd_en,
    input  logic [sorg_pkg::IDX_BITS-1:0] rd_idx,
    output sorg_pkg::entry_t              rd_entry
);

    sorg_pkg::entry_t mem [sorg_pkg::TABLE_DEPTH];
    sorg_pkg::entry_t rd_entry_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx] <= wr.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= mem[rd_idx];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ----- rtl/sorg_match.sv -----
// ----------------------------------------------------------------------------
// sorg_match
// Shared range compare: registers (probe - start) < span for one entry.
// ----------------------------------------------------------------------------
module sorg_match (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           valid,
    input  logic [sorg_pkg::ADDR_BITS-1:0] probe,
    input  sorg_pkg::entry_t               entry,
    output logic                           hit
);

    logic [sorg_pkg::ADDR_BITS-1:0] offset;
    logic                           hit_reg;
    logic                           hit_next;

    always_comb begin
        offset   = probe - entry.start;
        hit_next = valid && (offset < entry.span);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule
